@@ sv/hsv_to_rgb_color_unit_macros.svh @@
`ifndef HSV_TO_RGB_COLOR_UNIT_MACROS_SVH
`define HSV_TO_RGB_COLOR_UNIT_MACROS_SVH

// same-cycle implication, checked on clk while out of reset
`define HSV_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on clk while out of reset
`define HSV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/hsv2rgb_pkg.sv @@
`timescale 1ns / 1ps

package hsv2rgb_pkg;

    // pipeline depth and stage positions
    localparam int STAGES   = 7;
    localparam int ST_WRAP  = 0;
    localparam int ST_HUE   = 1;
    localparam int ST_SECT  = 2;
    localparam int ST_COEF  = 3;
    localparam int ST_PROD  = 4;
    localparam int ST_LEVEL = 5;
    localparam int ST_OUT   = 6;

    // hue reduction: offset is a multiple of 360 that makes any 16-bit hue positive
    localparam logic [16:0] HUE_OFFSET = 17'd33120;
    localparam logic [16:0] HUE_RECIP  = 17'd93207;     // ceil(2^25 / 360)
    localparam int          HUE_SHIFT  = 25;
    localparam logic [16:0] HUE_TURN   = 17'd360;

    // sector split: ceil(2^16 / 60)
    localparam logic [10:0] SEC_RECIP  = 11'd1093;
    localparam int          SEC_SHIFT  = 16;
    localparam logic [8:0]  SEC_DEG    = 9'd60;
    localparam logic [5:0]  SEC_DEG_6  = 6'd60;

    localparam logic [6:0]  PCT_MAX    = 7'd100;
    localparam logic [14:0] LEVEL_MAX  = 15'd255;
    localparam logic [12:0] PCT_DEG    = 13'd6000;

    // reciprocals for the three final divisions
    localparam logic [15:0] VV_RECIP   = 16'd41944;      // ceil(2^22 / 100)
    localparam int          VV_SHIFT   = 22;
    localparam logic [21:0] P_RECIP    = 22'd3435974;    // ceil(2^35 / 10000)
    localparam int          P_SHIFT    = 35;
    localparam logic [26:0] QT_RECIP   = 27'd117281241;  // ceil(2^46 / 600000)
    localparam int          QT_SHIFT   = 46;

    // hue sectors
    localparam logic [2:0] SEC_RED_YEL  = 3'd0;
    localparam logic [2:0] SEC_YEL_GRN  = 3'd1;
    localparam logic [2:0] SEC_GRN_CYAN = 3'd2;
    localparam logic [2:0] SEC_CYAN_BLU = 3'd3;
    localparam logic [2:0] SEC_BLU_MAG  = 3'd4;
    localparam logic [2:0] SEC_MAG_RED  = 3'd5;

    typedef struct packed {
        logic [STAGES-1:0] en;   // stage load enables
        logic [STAGES-1:0] vld;  // stage valid bits
    } pipe_ctl_t;

    typedef struct packed {
        logic [2:0]  sector;
        logic [5:0]  rem;
        logic [14:0] base;   // 255 * value
        logic [6:0]  sat;
    } hue_info_t;

    typedef struct packed {
        logic [2:0] sector;
        logic [7:0] vv;
        logic [7:0] p;
        logic [7:0] q;
        logic [7:0] t;
    } level_set_t;

endpackage

@@ sv/hsv2rgb_ctrl.sv @@
`timescale 1ns / 1ps

module hsv2rgb_ctrl
    import hsv2rgb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      out_ready,
    output pipe_ctl_t ctl
);

    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] vld_next;
    logic [STAGES-1:0] en;

    // a stage loads when empty or when the one after it moves on
    always_comb
    begin
        en[STAGES-1] = !vld_reg[STAGES-1] || out_ready;
        for (int i = STAGES - 2; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    always_comb
    begin
        vld_next = vld_reg;
        if (en[0])
        begin
            vld_next[0] = in_valid;
        end
        for (int i = 1; i < STAGES; i++)
        begin
            if (en[i])
            begin
                vld_next[i] = vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign ctl.en  = en;
    assign ctl.vld = vld_reg;

endmodule

@@ sv/hsv2rgb_hue.sv @@
`timescale 1ns / 1ps

module hsv2rgb_hue
    import hsv2rgb_pkg::*;
(
    input  logic        clk,
    input  pipe_ctl_t   ctl,
    input  logic [15:0] hue,
    input  logic [15:0] saturation,
    input  logic [15:0] brightness,
    output hue_info_t   info
);

    // stage: offset hue, quotient by 360, clamp percents
    logic [17:0] x_sum;
    logic [16:0] x_next;
    logic [33:0] quo_prod;
    logic [7:0]  quo_next;
    logic [6:0]  sat_next;
    logic [6:0]  val_next;
    logic [16:0] x_reg;
    logic [7:0]  quo_reg;
    logic [6:0]  sat1_reg;
    logic [6:0]  val_reg;

    function automatic logic [6:0] clamp_pct(input logic [15:0] pct);
        logic [6:0] res;
        if (pct[15])
        begin
            res = 7'd0;
        end
        else if (pct > {9'd0, PCT_MAX})
        begin
            res = PCT_MAX;
        end
        else
        begin
            res = pct[6:0];
        end
        return res;
    endfunction

    assign x_sum    = {{2{hue[15]}}, hue} + {1'b0, HUE_OFFSET};
    assign x_next   = x_sum[16:0];
    assign quo_prod = {17'd0, x_next} * {17'd0, HUE_RECIP};
    assign quo_next = quo_prod[HUE_SHIFT+7:HUE_SHIFT];
    assign sat_next = clamp_pct(saturation);
    assign val_next = clamp_pct(brightness);

    always_ff @(posedge clk)
    begin
        if (ctl.en[ST_WRAP])
        begin
            x_reg    <= x_next;
            quo_reg  <= quo_next;
            sat1_reg <= sat_next;
            val_reg  <= val_next;
        end
    end

    // stage: hue in 0..359, base = 255 * value
    logic [16:0] hu_full;
    logic [8:0]  hu_next;
    logic [14:0] base_next;
    logic [8:0]  hu_reg;
    logic [14:0] base2_reg;
    logic [6:0]  sat2_reg;

    assign hu_full   = x_reg - ({9'd0, quo_reg} * HUE_TURN);
    assign hu_next   = hu_full[8:0];
    assign base_next = {8'd0, val_reg} * LEVEL_MAX;

    always_ff @(posedge clk)
    begin
        if (ctl.en[ST_HUE])
        begin
            hu_reg    <= hu_next;
            base2_reg <= base_next;
            sat2_reg  <= sat1_reg;
        end
    end

    // stage: sector and position inside it
    logic [19:0] sec_prod;
    logic [2:0]  sector_next;
    logic [8:0]  rem_full;
    hue_info_t   info_reg;

    assign sec_prod    = {11'd0, hu_reg} * {9'd0, SEC_RECIP};
    assign sector_next = sec_prod[SEC_SHIFT+2:SEC_SHIFT];
    assign rem_full    = hu_reg - ({6'd0, sector_next} * SEC_DEG);

    always_ff @(posedge clk)
    begin
        if (ctl.en[ST_SECT])
        begin
            info_reg.sector <= sector_next;
            info_reg.rem    <= rem_full[5:0];
            info_reg.base   <= base2_reg;
            info_reg.sat    <= sat2_reg;
        end
    end

    assign info = info_reg;

endmodule

@@ sv/hsv2rgb_level.sv @@
`timescale 1ns / 1ps

module hsv2rgb_level
    import hsv2rgb_pkg::*;
(
    input  logic       clk,
    input  pipe_ctl_t  ctl,
    input  hue_info_t  info,
    output level_set_t levels
);

    // stage: channel coefficients and vv
    logic [12:0] srem_q;
    logic [5:0]  rem_t;
    logic [12:0] srem_t;
    logic [30:0] vv_prod;
    logic [14:0] base4_reg;
    logic [12:0] aq_reg;
    logic [12:0] at_reg;
    logic [6:0]  pn_reg;
    logic [7:0]  vv4_reg;
    logic [2:0]  sec4_reg;

    assign srem_q  = {6'd0, info.sat} * {7'd0, info.rem};
    assign rem_t   = SEC_DEG_6 - info.rem;
    assign srem_t  = {6'd0, info.sat} * {7'd0, rem_t};
    assign vv_prod = {16'd0, info.base} * {15'd0, VV_RECIP};

    always_ff @(posedge clk)
    begin
        if (ctl.en[ST_COEF])
        begin
            base4_reg <= info.base;
            aq_reg    <= PCT_DEG - srem_q;
            at_reg    <= PCT_DEG - srem_t;
            pn_reg    <= PCT_MAX - info.sat;
            vv4_reg   <= vv_prod[VV_SHIFT+7:VV_SHIFT];
            sec4_reg  <= info.sector;
        end
    end

    // stage: scaled numerators
    logic [21:0] np_reg;
    logic [27:0] nq_reg;
    logic [27:0] nt_reg;
    logic [7:0]  vv5_reg;
    logic [2:0]  sec5_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.en[ST_PROD])
        begin
            np_reg   <= {7'd0, base4_reg} * {15'd0, pn_reg};
            nq_reg   <= {13'd0, base4_reg} * {15'd0, aq_reg};
            nt_reg   <= {13'd0, base4_reg} * {15'd0, at_reg};
            vv5_reg  <= vv4_reg;
            sec5_reg <= sec4_reg;
        end
    end

    // stage: divide by 10000 and 600000 through reciprocals
    logic [43:0] p_prod;
    logic [54:0] q_prod;
    logic [54:0] t_prod;
    level_set_t  lvl_reg;

    assign p_prod = {22'd0, np_reg} * {22'd0, P_RECIP};
    assign q_prod = {27'd0, nq_reg} * {28'd0, QT_RECIP};
    assign t_prod = {27'd0, nt_reg} * {28'd0, QT_RECIP};

    always_ff @(posedge clk)
    begin
        if (ctl.en[ST_LEVEL])
        begin
            lvl_reg.sector <= sec5_reg;
            lvl_reg.vv     <= vv5_reg;
            lvl_reg.p      <= p_prod[P_SHIFT+7:P_SHIFT];
            lvl_reg.q      <= q_prod[QT_SHIFT+7:QT_SHIFT];
            lvl_reg.t      <= t_prod[QT_SHIFT+7:QT_SHIFT];
        end
    end

    assign levels = lvl_reg;

endmodule

@@ sv/hsv_to_rgb_color_unit.sv @@
`timescale 1ns / 1ps
// hsv to rgb color unit: converts one hsv color per transaction into 8-bit
// red, green and blue. hue is any signed 16-bit angle in degrees and is
// wrapped into 0..359; saturation and brightness are signed percents that
// are clamped into 0..100. the channel levels are exact integer results
// truncated toward zero. the pipeline is seven register stages deep, and
// one transaction is taken every cycle while the output side keeps up.
// each stage has its own valid bit and loads when it is empty or moving
// on, so bubbles close up and the input keeps flowing while a finished
// result waits on the output register.

`include "hsv_to_rgb_color_unit_macros.svh"

module hsv_to_rgb_color_unit
    import hsv2rgb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // hue [15:0], saturation [31:16], brightness [47:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // red [7:0], green [15:8], blue [23:16]
);

    pipe_ctl_t  ctl;
    hue_info_t  info;
    level_set_t levels;

    // valid and load-enable chain for all stages
    hsv2rgb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .out_ready (m_tready),
        .ctl       (ctl)
    );

    // stages one to three: hue wrap, sector, clamped percents
    hsv2rgb_hue u_hue (
        .clk        (clk),
        .ctl        (ctl),
        .hue        (s_tdata[15:0]),
        .saturation (s_tdata[31:16]),
        .brightness (s_tdata[47:32]),
        .info       (info)
    );

    // stages four to six: vv, p, q and t levels
    hsv2rgb_level u_level (
        .clk    (clk),
        .ctl    (ctl),
        .info   (info),
        .levels (levels)
    );

    // final stage: the sector picks which level goes to which channel
    logic [7:0] red_next;
    logic [7:0] green_next;
    logic [7:0] blue_next;
    logic [7:0] red_reg;
    logic [7:0] green_reg;
    logic [7:0] blue_reg;

    always_comb
    begin
        unique case (levels.sector)
            SEC_RED_YEL:
            begin
                red_next   = levels.vv;
                green_next = levels.t;
                blue_next  = levels.p;
            end
            SEC_YEL_GRN:
            begin
                red_next   = levels.q;
                green_next = levels.vv;
                blue_next  = levels.p;
            end
            SEC_GRN_CYAN:
            begin
                red_next   = levels.p;
                green_next = levels.vv;
                blue_next  = levels.t;
            end
            SEC_CYAN_BLU:
            begin
                red_next   = levels.p;
                green_next = levels.q;
                blue_next  = levels.vv;
            end
            SEC_BLU_MAG:
            begin
                red_next   = levels.t;
                green_next = levels.p;
                blue_next  = levels.vv;
            end
            // magenta to red sector
            default:
            begin
                red_next   = levels.vv;
                green_next = levels.p;
                blue_next  = levels.q;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en[ST_OUT])
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    // handshake
    assign s_tready = ctl.en[ST_WRAP];
    assign m_tvalid = ctl.vld[ST_OUT];
    assign m_tdata  = {blue_reg, green_reg, red_reg};

    // an accepted transaction always lands in the first stage
    `HSV_ASSERT_NEXT(a_accept_lands, s_tvalid && s_tready, ctl.vld[ST_WRAP], "accepted transaction lost at entry")

    // reciprocal split of the hue must give a sector below six and a position below sixty
    `HSV_ASSERT_NOW(a_sector_range, ctl.vld[ST_SECT], info.sector <= SEC_MAG_RED && info.rem < SEC_DEG_6, "hue sector out of range")

    // a delivered result with nothing behind it must not be shown again
    `HSV_ASSERT_NEXT(a_no_repeat, m_tvalid && m_tready && !ctl.vld[ST_LEVEL], !m_tvalid, "result repeated on output")

    // an empty stage is always free to load
    `HSV_ASSERT_NOW(a_empty_loads, !ctl.vld[ST_PROD], ctl.en[ST_PROD], "empty stage held")

endmodule
